FILE: src/prescaled_pwm_timer_assert.svh
// Assertion macros for the prescaled PWM timer.
`ifndef PRESCALED_PWM_TIMER_ASSERT_SVH
`define PRESCALED_PWM_TIMER_ASSERT_SVH

// Same-cycle implication, checked once reset is released.
`define PPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prescaled_pwm_timer: same-cycle check failed");

// Next-cycle implication, checked once reset is released.
`define PPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prescaled_pwm_timer: next-cycle check failed");

`endif

FILE: src/ppt_pkg.sv
// Shared types and codes for the prescaled PWM timer.
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int DATA_W    = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRELOAD = 2'd3;

    localparam logic [CFG_W-1:0] RATIO_RESET  = 17'd1;
    localparam logic [CFG_W-1:0] PERIOD_RESET = 17'd65536;

    // transaction op codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // bus register addresses
    localparam logic [1:0] ADDR_CTRL    = 2'd0;
    localparam logic [1:0] ADDR_STATUS  = 2'd1;
    localparam logic [1:0] ADDR_EVENT   = 2'd2;
    localparam logic [1:0] ADDR_COMPARE = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        reg_addr;
        logic [DATA_W-1:0] write_value;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              pwm_level;
        logic              update_pending;
        logic [DATA_W-1:0] count_now;
    } result_t;

    typedef struct packed {
        logic pwm_mode;
        logic preload_on;
    } mode_t;

endpackage

`default_nettype wire

FILE: src/ppt_cfg.sv
// Configuration register bank; stores ratio and period as clamped terminal counts, plus the mode and preload flags.
`timescale 1ns / 1ps
`default_nettype none

module ppt_cfg #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_write_en,
    input  wire [ppt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [ppt_pkg::CFG_W-1:0]        cfg_data,
    output logic [COUNT_WIDTH-1:0]          ratio_top,
    output logic [COUNT_WIDTH-1:0]          period_top,
    output ppt_pkg::mode_t                  mode
);
    import ppt_pkg::*;

    localparam int ExtW = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;

    logic [COUNT_WIDTH-1:0] ratio_top_reg;
    logic [COUNT_WIDTH-1:0] period_top_reg;
    mode_t                  mode_reg;

    // zero acts as 1, above 2^COUNT_WIDTH saturates; result is value minus one
    function automatic logic [COUNT_WIDTH-1:0] clamp_top(input logic [CFG_W-1:0] v);
        logic [ExtW-1:0] v_ext;
        logic [ExtW-1:0] lim;
        logic [ExtW-1:0] top;
        v_ext = ExtW'(v);
        lim   = ExtW'(1) << COUNT_WIDTH;
        if (v_ext == '0)
            top = '0;
        else if (v_ext > lim)
            top = lim - ExtW'(1);
        else
            top = v_ext - ExtW'(1);
        return top[COUNT_WIDTH-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_top_reg  <= clamp_top(RATIO_RESET);
            period_top_reg <= clamp_top(PERIOD_RESET);
            mode_reg       <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_RATIO:   ratio_top_reg       <= clamp_top(cfg_data);
                CFG_PERIOD:  period_top_reg      <= clamp_top(cfg_data);
                CFG_MODE:    mode_reg.pwm_mode   <= cfg_data[0];
                CFG_PRELOAD: mode_reg.preload_on <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign ratio_top  = ratio_top_reg;
    assign period_top = period_top_reg;
    assign mode       = mode_reg;

endmodule

`default_nettype wire

FILE: src/ppt_core.sv
// Timer state: prescaler, main counter, compare registers, flags, and result logic.
`timescale 1ns / 1ps
`default_nettype none

module ppt_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     fire,
    input  ppt_pkg::item_t          item,
    input  ppt_pkg::mode_t          mode,
    input  wire [COUNT_WIDTH-1:0]   ratio_top,
    input  wire [COUNT_WIDTH-1:0]   period_top,
    output ppt_pkg::result_t        result_next
);
    import ppt_pkg::*;

    localparam int WideW = (COUNT_WIDTH > DATA_W) ? COUNT_WIDTH : DATA_W;

    logic [COUNT_WIDTH-1:0] presc_reg,  presc_next;
    logic [COUNT_WIDTH-1:0] main_reg,   main_next;
    logic [COUNT_WIDTH-1:0] act_reg,    act_next;
    logic [COUNT_WIDTH-1:0] pend_reg,   pend_next;
    logic                   run_reg,    run_next;
    logic                   oe_reg,     oe_next;
    logic                   flag_reg,   flag_next;

    logic [WideW-1:0]       wv_wide;
    logic [WideW-1:0]       pend_wide;
    logic [WideW-1:0]       main_wide;
    logic [COUNT_WIDTH-1:0] wv_cnt;
    logic [DATA_W-1:0]      rd;
    logic                   step;
    logic                   upd;
    logic                   active;

    assign wv_wide   = WideW'(item.write_value);
    assign wv_cnt    = wv_wide[COUNT_WIDTH-1:0];
    assign pend_wide = WideW'(pend_reg);

    always_comb
    begin
        presc_next = presc_reg;
        main_next  = main_reg;
        act_next   = act_reg;
        pend_next  = pend_reg;
        run_next   = run_reg;
        oe_next    = oe_reg;
        flag_next  = flag_reg;
        rd         = '0;
        step       = 1'b0;
        upd        = 1'b0;

        case (item.op)
            OP_TICK:
            begin
                if (run_reg)
                begin
                    if (presc_reg >= ratio_top)
                    begin
                        presc_next = '0;
                        step       = 1'b1;
                    end
                    else
                    begin
                        presc_next = presc_reg + 1'b1;
                    end
                end
            end
            OP_WRITE:
            begin
                case (item.reg_addr)
                    ADDR_CTRL:
                    begin
                        run_next = item.write_value[0];
                        oe_next  = item.write_value[1];
                    end
                    ADDR_STATUS:
                    begin
                        if (!item.write_value[0])
                            flag_next = 1'b0;
                    end
                    ADDR_EVENT:
                    begin
                        if (item.write_value[0])
                        begin
                            presc_next = '0;
                            main_next  = '0;
                            upd        = 1'b1;
                        end
                    end
                    ADDR_COMPARE:
                    begin
                        pend_next = wv_cnt;
                        if (!mode.preload_on)
                            act_next = wv_cnt;
                    end
                    default: ;
                endcase
            end
            OP_READ:
            begin
                case (item.reg_addr)
                    ADDR_CTRL:    rd = DATA_W'({oe_reg, run_reg});
                    ADDR_STATUS:  rd = DATA_W'(flag_reg);
                    ADDR_EVENT:   rd = '0;
                    ADDR_COMPARE: rd = pend_wide[DATA_W-1:0];
                    default:      rd = '0;
                endcase
            end
            default: ;
        endcase

        // wrap when at or past the terminal count (period may have shrunk)
        if (step)
        begin
            if (main_reg >= period_top)
            begin
                main_next = '0;
                upd       = 1'b1;
            end
            else
            begin
                main_next = main_reg + 1'b1;
            end
        end

        if (upd)
        begin
            act_next  = pend_reg;
            flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presc_reg <= '0;
            main_reg  <= '0;
            act_reg   <= '0;
            pend_reg  <= '0;
            run_reg   <= 1'b0;
            oe_reg    <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else if (fire)
        begin
            presc_reg <= presc_next;
            main_reg  <= main_next;
            act_reg   <= act_next;
            pend_reg  <= pend_next;
            run_reg   <= run_next;
            oe_reg    <= oe_next;
            flag_reg  <= flag_next;
        end
    end

    assign active    = mode.pwm_mode ? (main_next >= act_next) : (main_next < act_next);
    assign main_wide = WideW'(main_next);

    assign result_next.read_data      = rd;
    assign result_next.pwm_level      = oe_next & active;
    assign result_next.update_pending = flag_next;
    assign result_next.count_now      = main_wide[DATA_W-1:0];

endmodule

`default_nettype wire

FILE: src/prescaled_pwm_timer.sv
// Top level of the prescaled PWM timer: input register, config bank, core, result register.
//
//  channel  direction  handshake            payload
//  in       to block   in_valid/in_ready    op, reg_addr, write_value
//  out      from block out_valid/out_ready  read_data, pwm_level, update_pending, count_now
//  cfg      to block   cfg_write_en         cfg_index, cfg_data
//
// One transaction per clock sustained while out_ready stays high; the path is the input
// register, then the result register. All state updates for a transaction happen in the one
// cycle it leaves the input register, set by the core's compare/increment logic.
// Reset is asynchronous, active low: counters, compares and flags clear, the
// timer is stopped with its output off. When out_ready is low the result holds
// and the input register still takes one more transaction before in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

`include "prescaled_pwm_timer_assert.svh"

module prescaled_pwm_timer #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_write_en,
    input  wire [ppt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [ppt_pkg::CFG_W-1:0]        cfg_data,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire [1:0]                       op,
    input  wire [1:0]                       reg_addr,
    input  wire [ppt_pkg::DATA_W-1:0]       write_value,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [ppt_pkg::DATA_W-1:0]      read_data,
    output logic                            pwm_level,
    output logic                            update_pending,
    output logic [ppt_pkg::DATA_W-1:0]      count_now
);
    import ppt_pkg::*;

    logic                   in_valid_reg;
    item_t                  item_reg;
    logic                   out_valid_reg;
    result_t                result_reg;
    result_t                result_next;
    logic                   advance;
    logic                   fire;
    logic [COUNT_WIDTH-1:0] ratio_top;
    logic [COUNT_WIDTH-1:0] period_top;
    mode_t                  mode;
    logic                   read_fire;
    logic [DATA_W:0]        read_watch;

    // result slot frees when empty or being taken; input slot frees likewise
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire)
                result_reg <= result_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op          <= op;
            item_reg.reg_addr    <= reg_addr;
            item_reg.write_value <= write_value;
        end
    end

    ppt_cfg #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ratio_top    (ratio_top),
        .period_top   (period_top),
        .mode         (mode)
    );

    ppt_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item_reg),
        .mode        (mode),
        .ratio_top   (ratio_top),
        .period_top  (period_top),
        .result_next (result_next)
    );

    assign out_valid      = out_valid_reg;
    assign read_data      = result_reg.read_data;
    assign pwm_level      = result_reg.pwm_level;
    assign update_pending = result_reg.update_pending;
    assign count_now      = result_reg.count_now;

    assign read_fire  = fire && (item_reg.op == OP_READ);
    assign read_watch = {result_reg.update_pending, result_reg.count_now};

    // a stalled result must never be overwritten
    `PPT_ASSERT_NOW(a_no_overwrite, out_valid_reg && !out_ready, !fire)
    // a read leaves counter and flag untouched
    `PPT_ASSERT_NEXT(a_read_no_side_effect, read_fire, $stable(read_watch))
    // read data is zero for anything but a read
    `PPT_ASSERT_NEXT(a_rd_zero, fire && item_reg.op != OP_READ, result_reg.read_data == '0)

endmodule

`default_nettype wire
